@@ rtl/plist_pkg.sv @@
// Shared definitions for the positional list engine.
// Field widths, command codes and the result record used by the sequencer and top level.
// No dependencies.
package plist_pkg;

    localparam int CMD_BITS       = 3;
    localparam int POS_BITS       = 5;
    localparam int ITEM_IN_BITS   = 32;
    localparam int ITEM_OUT_BITS  = 32;
    localparam int COUNT_OUT_BITS = 5;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_ITEM_BITS = 32;

    localparam logic [CMD_BITS-1:0] CMD_INSERT      = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_APPEND      = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE      = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE_LAST = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_READ        = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR       = 3'd5;

    typedef struct packed {
        logic                      ok;
        logic [ITEM_OUT_BITS-1:0]  item;
        logic [COUNT_OUT_BITS-1:0] count;
        logic                      is_empty;
    } t_result;

endpackage

@@ rtl/plist_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/plist_seq.sv @@
// Command sequencer: decodes a command, shifts list entries through the RAM one per cycle,
// keeps the item count and forms the result. Depends on plist_pkg.
module plist_seq #(
    parameter int CAPACITY  = plist_pkg::DEF_CAPACITY,
    parameter int ITEM_BITS = plist_pkg::DEF_ITEM_BITS,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [plist_pkg::CMD_BITS-1:0]     i_command,
    input  logic [plist_pkg::POS_BITS-1:0]     i_position,
    input  logic [plist_pkg::ITEM_IN_BITS-1:0] i_item_in,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output plist_pkg::t_result                o_res,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic [ITEM_BITS-1:0]              i_rd_data,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [ITEM_BITS-1:0]              o_wr_data
);

    localparam int PCW   = (CW > plist_pkg::POS_BITS) ? CW : plist_pkg::POS_BITS;
    localparam int OUT_W = plist_pkg::ITEM_OUT_BITS;
    localparam int CNT_W = plist_pkg::COUNT_OUT_BITS;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_RESP} t_state;
    typedef enum logic [1:0] {OP_PUT, OP_TAKE, OP_PEEK} t_op;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    t_op                  r_op, n_op;
    logic [AW-1:0]        r_pos, n_pos;
    logic [ITEM_BITS-1:0] r_item_new, n_item_new;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_first, n_first;
    logic                 r_p_vld, n_p_vld;
    logic [AW-1:0]        r_p_addr, n_p_addr;
    logic                 r_p_first, n_p_first;
    logic [ITEM_BITS-1:0] r_got, n_got;
    logic                 r_ok, n_ok;

    logic [PCW-1:0] pos_ext;
    logic [PCW-1:0] cnt_ext;
    logic [PCW-1:0] eff_pos;
    logic           is_full;
    logic           cmd_ok;
    logic           do_run;
    t_op            cmd_op;

    always_comb begin
        pos_ext = PCW'(i_position);
        cnt_ext = PCW'(r_count);
        is_full = (r_count >= CW'(CAPACITY));
        cmd_ok  = 1'b0;
        eff_pos = pos_ext;
        cmd_op  = OP_PEEK;
        do_run  = 1'b0;
        case (i_command)
            plist_pkg::CMD_INSERT: begin
                cmd_ok = (pos_ext <= cnt_ext) && !is_full;
                cmd_op = OP_PUT;
                do_run = 1'b1;
            end
            plist_pkg::CMD_APPEND: begin
                cmd_ok  = !is_full;
                eff_pos = cnt_ext;
                cmd_op  = OP_PUT;
                do_run  = 1'b1;
            end
            plist_pkg::CMD_REMOVE: begin
                cmd_ok = (pos_ext < cnt_ext);
                cmd_op = OP_TAKE;
                do_run = 1'b1;
            end
            plist_pkg::CMD_REMOVE_LAST: begin
                cmd_ok  = (r_count != '0);
                eff_pos = cnt_ext - PCW'(1);
                cmd_op  = OP_TAKE;
                do_run  = 1'b1;
            end
            plist_pkg::CMD_READ: begin
                cmd_ok = (pos_ext < cnt_ext);
                cmd_op = OP_PEEK;
                do_run = 1'b1;
            end
            plist_pkg::CMD_CLEAR: begin
                cmd_ok = 1'b1;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_op       = r_op;
        n_pos      = r_pos;
        n_item_new = r_item_new;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_first    = r_first;
        n_p_vld    = r_p_vld;
        n_p_addr   = r_p_addr;
        n_p_first  = r_p_first;
        n_got      = r_got;
        n_ok       = r_ok;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_ptr;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_p_addr + AW'(1);
        o_wr_data  = i_rd_data;
        o_ready    = (r_state == S_IDLE);
        o_res_valid = (r_state == S_RESP);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ok       = cmd_ok;
                    n_got      = '0;
                    n_op       = cmd_op;
                    n_pos      = AW'(eff_pos);
                    n_item_new = ITEM_BITS'(i_item_in);
                    n_first    = 1'b1;
                    n_p_vld    = 1'b0;
                    if (cmd_op == OP_PUT) begin
                        n_ptr  = AW'(cnt_ext - PCW'(1));
                        n_left = CW'(cnt_ext - eff_pos);
                    end else if (cmd_op == OP_TAKE) begin
                        n_ptr  = AW'(eff_pos);
                        n_left = CW'(cnt_ext - eff_pos);
                    end else begin
                        n_ptr  = AW'(eff_pos);
                        n_left = CW'(1);
                    end
                    if (cmd_ok && do_run) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_RESP;
                        if (cmd_ok) begin
                            n_count = '0;
                        end
                    end
                end
            end
            S_RUN: begin
                if (r_left != '0) begin
                    o_rd_en   = 1'b1;
                    n_ptr     = (r_op == OP_PUT) ? r_ptr - AW'(1) : r_ptr + AW'(1);
                    n_left    = r_left - CW'(1);
                    n_p_vld   = 1'b1;
                    n_p_addr  = r_ptr;
                    n_p_first = r_first;
                    n_first   = 1'b0;
                end else begin
                    n_p_vld = 1'b0;
                end
                if (r_p_vld) begin
                    case (r_op)
                        OP_PUT: begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_p_addr + AW'(1);
                        end
                        OP_TAKE: begin
                            if (r_p_first) begin
                                n_got = i_rd_data;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_p_addr - AW'(1);
                            end
                        end
                        default: begin
                            n_got = i_rd_data;
                        end
                    endcase
                end
                if (r_left == '0 && !r_p_vld) begin
                    n_state = S_RESP;
                    if (r_op == OP_PUT) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_pos;
                        o_wr_data = r_item_new;
                        n_count   = r_count + CW'(1);
                    end else if (r_op == OP_TAKE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.ok       = r_ok;
        o_res.item     = OUT_W'(r_got);
        o_res.count    = CNT_W'(r_count);
        o_res.is_empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_p_vld <= n_p_vld;
        end
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_item_new <= n_item_new;
        r_ptr      <= n_ptr;
        r_left     <= n_left;
        r_first    <= n_first;
        r_p_addr   <= n_p_addr;
        r_p_first  <= n_p_first;
        r_got      <= n_got;
        r_ok       <= n_ok;
    end

endmodule

@@ rtl/positional_list_engine.sv @@
// Top level of the positional list engine: entry RAM, command sequencer, result register.
// Depends on plist_pkg, plist_ram and plist_seq.
//
//   channel   handshake            payload
//   command   i_valid / o_ready    i_command, i_position, i_item_in
//   result    o_valid / i_ready    o_ok, o_item_out, o_count, o_is_empty
//
// One item at a time. Insert and remove move one RAM entry per cycle through the single
// read and write port; read fetches one entry, and clear and rejected commands go straight
// to the result state. Reset empties the list at once; no clearing pass. A stalled result
// waits in the output register while the next item is taken; a second result waits in
// the sequencer.
module positional_list_engine #(
    parameter int CAPACITY  = plist_pkg::DEF_CAPACITY,
    parameter int ITEM_BITS = plist_pkg::DEF_ITEM_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [plist_pkg::CMD_BITS-1:0]       i_command,
    input  logic [plist_pkg::POS_BITS-1:0]       i_position,
    input  logic [plist_pkg::ITEM_IN_BITS-1:0]   i_item_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_ok,
    output logic [plist_pkg::ITEM_OUT_BITS-1:0]  o_item_out,
    output logic [plist_pkg::COUNT_OUT_BITS-1:0] o_count,
    output logic                                 o_is_empty
);

    localparam int AW = $clog2(CAPACITY);

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ITEM_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ITEM_BITS-1:0] wr_data;

    logic               res_valid;
    logic               res_ready;
    plist_pkg::t_result res;

    logic               r_out_vld;
    plist_pkg::t_result r_out;

    plist_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    plist_seq #(
        .CAPACITY  (CAPACITY),
        .ITEM_BITS (ITEM_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_item_in   (i_item_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    assign res_ready = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_ok       = r_out.ok;
    assign o_item_out = r_out.item;
    assign o_count    = r_out.count;
    assign o_is_empty = r_out.is_empty;

endmodule
